/* hw/rtl/rcm_pkg.sv */
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared widths, register codes and reset values of the RGBA color matrix.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int COEF_FRAC_BITS = 8;   // fractional bits of a weight
  localparam int PIX_W          = 8;   // one color channel
  localparam int COEF_W         = 16;  // one signed weight
  localparam int NUM_CH         = 4;   // r, g, b, a
  localparam int CFG_W          = COEF_W * NUM_CH;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_STAGES     = 4;   // multiply, pair add, final add, clamp

  // product of a zero-extended pixel and a signed weight
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PAIR_W + 1;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_MIN = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_ROW   = 3'd0,
    REG_GREEN_ROW = 3'd1,
    REG_BLUE_ROW  = 3'd2,
    REG_ALPHA_ROW = 3'd3
  } rcm_reg_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CFG_W-1:0] row_t;

  // per-stage load enables handed to each channel datapath
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } rcm_stage_ctl_t;

  // identity row: weight 1.0 on the diagonal lane
  function automatic row_t identity_row(input int lane);
    row_t one;
    one = row_t'(1) << COEF_FRAC_BITS;
    return one << (COEF_W * lane);
  endfunction

endpackage

/* hw/rtl/rcm_in_if.sv */
// ----------------------------------------------------------------------------
// rcm_in_if
// Input pixel channel: valid/ready with one RGBA pixel and last flag.
// ----------------------------------------------------------------------------
interface rcm_in_if import rcm_pkg::*; ();
  logic valid;
  logic ready;
  pix_t in_red;
  pix_t in_green;
  pix_t in_blue;
  pix_t in_alpha;
  logic in_last;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, in_last,
                  input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, in_last,
                  output ready);
endinterface

/* hw/rtl/rcm_out_if.sv */
// ----------------------------------------------------------------------------
// rcm_out_if
// Output pixel channel: valid/ready with one transformed pixel and last flag.
// ----------------------------------------------------------------------------
interface rcm_out_if import rcm_pkg::*; ();
  logic valid;
  logic ready;
  pix_t out_red;
  pix_t out_green;
  pix_t out_blue;
  pix_t out_alpha;
  logic out_last;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, out_last,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, out_last,
                  output ready);
endinterface

/* hw/rtl/rgba_color_matrix.sv */
// ----------------------------------------------------------------------------
// rgba_color_matrix
// RGBA pixel times a programmable 4x4 matrix of signed Q7.8 weights, each
// output floored and clamped to 0..255; the last flag rides along.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+--------------------------------------
//  px_in    | in  | valid/ready      | in_red/green/blue/alpha, in_last
//  px_out   | out | valid/ready      | out_red/green/blue/alpha, out_last
//  cfg      | in  | cfg_we (no wait) | cfg_index (row 0..3), cfg_data
//
//  One item per cycle sustained while px_out.ready holds; an accepted item
//  passes the multiply, pair add, final add and clamp/output registers in order.
//  Each stage holds its own valid bit and loads when it is empty or its
//  successor moves, so bubbles squeeze out and a stall at px_out backs up
//  stage by stage without losing or repeating an item.
//  rst (synchronous) empties the pipe and loads the identity matrix.
//  Row writes take effect on the next cycle; writes to indexes past the
//  alpha row are dropped.
//
module rgba_color_matrix import rcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  rcm_in_if.sink               px_in,
  rcm_out_if.source            px_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // --------------------------------------------------------------------------
  // matrix rows: one register per output channel
  // --------------------------------------------------------------------------
  row_t rows [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rows[c] <= identity_row(c);
      end
    end else if (cfg_we) begin
      unique case (rcm_reg_e'(cfg_index))
        REG_RED_ROW:   rows[0] <= cfg_data;
        REG_GREEN_ROW: rows[1] <= cfg_data;
        REG_BLUE_ROW:  rows[2] <= cfg_data;
        REG_ALPHA_ROW: rows[3] <= cfg_data;
        default: ;  // unmapped index, ignore
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: valid per stage, load enable rippling from the output
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] last;
  rcm_stage_ctl_t        ctl;

  always_comb begin
    ctl.en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || px_out.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ctl.en[i] = !valid[i] || ctl.en[i+1];
    end
  end

  assign px_in.ready = ctl.en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.en[0]) begin
        valid[0] <= px_in.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ctl.en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // last flag follows the same enables as the data
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      last[0] <= px_in.in_last;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (ctl.en[i]) begin
        last[i] <= last[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath: one dot-product pipe per output channel
  // --------------------------------------------------------------------------
  pix_t px [NUM_CH];
  pix_t result [NUM_CH];

  assign px[0] = px_in.in_red;
  assign px[1] = px_in.in_green;
  assign px[2] = px_in.in_blue;
  assign px[3] = px_in.in_alpha;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    rcm_channel u_channel (
      .clk    (clk),
      .ctl    (ctl),
      .row    (rows[c]),
      .px     (px),
      .result (result[c])
    );
  end

  assign px_out.valid     = valid[NUM_STAGES-1];
  assign px_out.out_red   = result[0];
  assign px_out.out_green = result[1];
  assign px_out.out_blue  = result[2];
  assign px_out.out_alpha = result[3];
  assign px_out.out_last  = last[NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------

  // input only backs up once every stage holds an item
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !px_in.ready |-> (&valid))
    else $error("input stalled with an empty stage");

  // a held stage keeps its item while the next one cannot take it
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (valid[1] && !ctl.en[2]) |=> valid[1])
    else $error("stalled item dropped from stage two");

  // an item accepted with the pipe moving, and the pipe still moving, reaches px_out.valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (px_in.valid && px_in.ready && (&ctl.en)) ##1 (&ctl.en) ##1 (&ctl.en)
      ##1 (&ctl.en) |=> px_out.valid)
    else $error("item lost in pipeline");

  // reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !px_out.valid)
    else $error("output valid right after reset");

endmodule

/* hw/rtl/rcm_channel.sv */
// ----------------------------------------------------------------------------
// rcm_channel
// One output channel: four-stage dot product of a pixel with a weight row,
// floor shift and clamp to the byte range.
// ----------------------------------------------------------------------------
module rcm_channel import rcm_pkg::*; (
  input  logic           clk,
  input  rcm_stage_ctl_t ctl,
  input  row_t           row,
  input  pix_t           px [NUM_CH],
  output pix_t           result
);

  logic signed [PROD_W-1:0] prod [NUM_CH];
  logic signed [PAIR_W-1:0] pair [2];
  logic signed [SUM_W-1:0]  sum;
  pix_t                     clamped;

  // stage 1: one 9x16 multiply per lane
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      for (int k = 0; k < NUM_CH; k++) begin
        prod[k] <= PROD_W'($signed({1'b0, px[k]}) *
                           $signed(row[k*COEF_W +: COEF_W]));
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
  end

  // stage 3: full sum
  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      sum <= SUM_W'(pair[0]) + SUM_W'(pair[1]);
    end
  end

  // negative -> 0; shifted value above byte range -> max
  always_comb begin
    if (sum[SUM_W-1]) begin
      clamped = PIX_MIN;
    end else if (|sum[SUM_W-2:COEF_FRAC_BITS+PIX_W]) begin
      clamped = PIX_MAX;
    end else begin
      clamped = sum[COEF_FRAC_BITS +: PIX_W];
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      result <= clamped;
    end
  end

endmodule
